FILE: design/rld_pkg.sv
// shared types, codes and constants of the raster line run-length decoder
// no dependencies; every other file of the block imports this package

package rld_pkg;

	// field widths of the channels and the configuration port
	localparam int unsigned OP_W     = 2;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned COORD_W  = 16;
	localparam int unsigned PIXEL_W  = 32;
	localparam int unsigned REP_W    = 9;
	localparam int unsigned BPP_W    = 3;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// default depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// input op codes
	localparam logic [OP_W-1:0] OP_START = 2'd0;
	localparam logic [OP_W-1:0] OP_DATA  = 2'd1;
	localparam logic [OP_W-1:0] OP_END   = 2'd2;

	// queued command codes
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_END   = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_SPAN      = 2'd0;
	localparam logic [KIND_W-1:0] KIND_END_CLEAN = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END_TRUNC = 2'd2;
	localparam logic [KIND_W-1:0] KIND_EXTRA     = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_LINES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BPP        = 2'd2;

	// packbits code values
	localparam logic [BYTE_W-1:0] FILL_CODE = 8'h80;
	localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;

	typedef struct packed {
		logic [COORD_W-1:0] row_width;
		logic [COORD_W-1:0] page_lines;
		logic [BPP_W-1:0]   bytes_per_pixel;
	} cfg_t;

	// one classified transaction as it waits in the queue
	typedef struct packed {
		logic [1:0]        cmd;
		logic [BYTE_W-1:0] data_byte;
		logic              is_fill;
		logic              is_run;
		logic [BYTE_W-1:0] lit_count;
		logic [BYTE_W-1:0] run_count;
		logic [REP_W-1:0]  copies;
	} q_item_t;

endpackage

FILE: design/rld_in_if.sv
// input channel of the decoder: op code and compressed byte with valid/ready
// depends on rld_pkg

interface rld_in_if;
	import rld_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output op, output data_byte, input ready);
	modport sink (input valid, input op, input data_byte, output ready);
endinterface

FILE: design/rld_out_if.sv
// output channel of the decoder: pixel spans and status with valid/ready
// depends on rld_pkg

interface rld_out_if;
	import rld_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [COORD_W-1:0] line_index;
	logic [COORD_W-1:0] start_x;
	logic [COORD_W-1:0] run_length;
	logic [PIXEL_W-1:0] pixel;
	logic               line_end;
	logic [REP_W-1:0]   repeat_count;
	logic               page_end;

	modport source (
		output valid, output kind, output line_index, output start_x, output run_length,
		output pixel, output line_end, output repeat_count, output page_end, input ready
	);
	modport sink (
		input valid, input kind, input line_index, input start_x, input run_length,
		input pixel, input line_end, input repeat_count, input page_end, output ready
	);
endinterface

FILE: design/rld_front.sv
// front end: takes input transactions and classifies them for the queue
// depends on rld_pkg and rld_in_if

module rld_front (
	rld_in_if.sink          in_ch,
	input  logic            queue_full,
	output logic            push,
	output rld_pkg::q_item_t push_item
);
	import rld_pkg::*;

	logic take;
	logic keep;

	assign in_ch.ready = !queue_full;
	assign take        = in_ch.valid && !queue_full;

	always_comb begin
		keep              = 1'b1;
		push_item.cmd     = CMD_BYTE;
		unique case (in_ch.op)
			OP_START: push_item.cmd = CMD_START;
			OP_DATA:  push_item.cmd = CMD_BYTE;
			OP_END:   push_item.cmd = CMD_END;
			default:  keep = 1'b0;
		endcase
		push_item.data_byte = in_ch.data_byte;
		push_item.is_fill   = (in_ch.data_byte == FILL_CODE);
		push_item.is_run    = !in_ch.data_byte[BYTE_W-1];
		// literal count is one minus the signed code
		push_item.lit_count = BYTE_W'(9'd257 - {1'b0, in_ch.data_byte});
		push_item.run_count = in_ch.data_byte + 1'b1;
		push_item.copies    = {1'b0, in_ch.data_byte} + 1'b1;
	end

	// op code 3 is taken and dropped
	assign push = take && keep;

endmodule

FILE: design/rld_queue.sv
// short queue between the front end and the decode back end
// depends on rld_pkg

module rld_queue #(
	parameter int unsigned DEPTH = rld_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rld_pkg::q_item_t push_item,
	output logic             full,
	input  logic             pop,
	output rld_pkg::q_item_t pop_item,
	output logic             empty
);
	import rld_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	q_item_t           items_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = items_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			items_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/rld_back.sv
// back end: decode state machine, span arithmetic and output register
// depends on rld_pkg and rld_out_if

module rld_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rld_pkg::cfg_t    cfg,
	input  logic             empty,
	input  rld_pkg::q_item_t pop_item,
	output logic             pop,
	rld_out_if.source        out_ch
);
	import rld_pkg::*;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_REPEAT = 3'd1;
	localparam logic [2:0] PH_CODE   = 3'd2;
	localparam logic [2:0] PH_RUNPIX = 3'd3;
	localparam logic [2:0] PH_LITPIX = 3'd4;

	// decode state
	logic [2:0]         phase_q,   phase_d;
	logic [COORD_W-1:0] column_q,  column_d;
	logic [COORD_W-1:0] line_q,    line_d;
	logic [REP_W-1:0]   copies_q,  copies_d;
	logic [BYTE_W-1:0]  lits_q,    lits_d;
	logic [BYTE_W-1:0]  run_q,     run_d;
	logic [1:0]         slot_q,    slot_d;
	logic [PIXEL_W-1:0] gather_q,  gather_d;

	// output register
	logic               out_valid_q;
	logic [KIND_W-1:0]  kind_q;
	logic [COORD_W-1:0] line_index_q;
	logic [COORD_W-1:0] start_x_q;
	logic [COORD_W-1:0] run_length_q;
	logic [PIXEL_W-1:0] pixel_q;
	logic               line_end_q;
	logic [REP_W-1:0]   repeat_q;
	logic               page_end_q;

	// result of this cycle
	logic               res_valid;
	logic [KIND_W-1:0]  res_kind;
	logic [COORD_W-1:0] res_x;
	logic [COORD_W-1:0] res_len;
	logic [PIXEL_W-1:0] res_pix;
	logic               res_le;
	logic [REP_W-1:0]   res_rep;
	logic               res_pe;

	// effective configuration
	logic [COORD_W-1:0] w_eff;
	logic [COORD_W-1:0] h_eff;
	logic [BPP_W-1:0]   bpp_eff;
	logic [PIXEL_W-1:0] mask;

	// span arithmetic
	logic [COORD_W:0]   col_diff;
	logic               w_gt_col;
	logic [COORD_W-1:0] rem;
	logic [COORD_W-1:0] want;
	logic               span_done;
	logic [COORD_W-1:0] span_len;
	logic [COORD_W:0]   line_diff;
	logic               h_gt_line;
	logic [COORD_W-1:0] left;
	logic               copies_lt_left;
	logic [REP_W-1:0]   rep;
	logic               pend;
	logic [COORD_W-1:0] next_line;

	// pixel gathering
	logic [PIXEL_W-1:0] shifted;
	logic [PIXEL_W-1:0] gathered;
	logic [2:0]         slot_inc;
	logic               gather_full;

	logic               emit;
	logic [PIXEL_W-1:0] emit_pix;
	logic [BYTE_W-1:0]  lits_dec;
	logic               is_idle;

	assign pop = !empty && (!out_valid_q || out_ch.ready);

	assign w_eff   = (cfg.row_width == '0) ? COORD_W'(1) : cfg.row_width;
	assign h_eff   = (cfg.page_lines == '0) ? COORD_W'(1) : cfg.page_lines;
	assign bpp_eff = (cfg.bytes_per_pixel == '0) ? BPP_W'(1) :
		((cfg.bytes_per_pixel > BPP_W'(4)) ? BPP_W'(4) : cfg.bytes_per_pixel);

	always_comb begin
		case (bpp_eff)
			BPP_W'(1): mask = 32'h0000_00FF;
			BPP_W'(2): mask = 32'h0000_FFFF;
			BPP_W'(3): mask = 32'h00FF_FFFF;
			default:   mask = 32'hFFFF_FFFF;
		endcase
	end

	// columns left in the line, at least one
	assign col_diff = {1'b0, w_eff} - {1'b0, column_q};
	assign w_gt_col = !col_diff[COORD_W] && (col_diff[COORD_W-1:0] != '0);
	assign rem      = w_gt_col ? col_diff[COORD_W-1:0] : COORD_W'(1);

	always_comb begin
		case (phase_q)
			PH_RUNPIX: want = {8'd0, run_q};
			PH_LITPIX: want = COORD_W'(1);
			default:   want = 16'hFFFF;
		endcase
	end

	assign span_done = (want >= rem);
	assign span_len  = span_done ? rem : want;

	// lines left on the page and the clipped repeat
	assign line_diff      = {1'b0, h_eff} - {1'b0, line_q};
	assign h_gt_line      = !line_diff[COORD_W] && (line_diff[COORD_W-1:0] != '0);
	assign left           = h_gt_line ? line_diff[COORD_W-1:0] : '0;
	assign copies_lt_left = ({7'd0, copies_q} < left);
	assign rep            = copies_lt_left ? copies_q : left[REP_W-1:0];
	assign pend           = !h_gt_line || !copies_lt_left;
	assign next_line      = line_q + {7'd0, rep};

	assign shifted     = {24'd0, pop_item.data_byte} << {slot_q, 3'b000};
	assign gathered    = gather_q | shifted;
	assign slot_inc    = {1'b0, slot_q} + 1'b1;
	assign gather_full = (slot_inc >= bpp_eff);
	assign lits_dec    = (lits_q != '0) ? lits_q - 1'b1 : '0;
	assign is_idle     = (phase_q == PH_IDLE) || (phase_q > PH_LITPIX);

	always_comb begin
		phase_d   = phase_q;
		column_d  = column_q;
		line_d    = line_q;
		copies_d  = copies_q;
		lits_d    = lits_q;
		run_d     = run_q;
		slot_d    = slot_q;
		gather_d  = gather_q;
		res_valid = 1'b0;
		res_kind  = KIND_SPAN;
		res_x     = '0;
		res_len   = '0;
		res_pix   = '0;
		res_le    = 1'b0;
		res_rep   = '0;
		res_pe    = 1'b0;
		emit      = 1'b0;
		emit_pix  = mask;

		if (pop) begin
			unique case (pop_item.cmd)
				CMD_START: begin
					column_d = '0;
					line_d   = '0;
					copies_d = '0;
					lits_d   = '0;
					run_d    = '0;
					slot_d   = '0;
					gather_d = '0;
					phase_d  = PH_REPEAT;
				end
				CMD_END: begin
					res_valid = 1'b1;
					res_kind  = is_idle ? KIND_END_CLEAN : KIND_END_TRUNC;
					phase_d   = PH_IDLE;
				end
				CMD_BYTE: begin
					unique case (phase_q)
						PH_REPEAT: begin
							copies_d = pop_item.copies;
							column_d = '0;
							phase_d  = PH_CODE;
						end
						PH_CODE: begin
							if (pop_item.is_fill) begin
								emit     = 1'b1;
								emit_pix = mask;
							end else begin
								slot_d   = '0;
								gather_d = '0;
								if (pop_item.is_run) begin
									run_d   = pop_item.run_count;
									phase_d = PH_RUNPIX;
								end else begin
									lits_d  = pop_item.lit_count;
									phase_d = PH_LITPIX;
								end
							end
						end
						PH_RUNPIX: begin
							if (!gather_full) begin
								slot_d   = slot_inc[1:0];
								gather_d = gathered;
							end else begin
								emit     = 1'b1;
								emit_pix = gathered & mask;
								slot_d   = '0;
								run_d    = '0;
								gather_d = '0;
								phase_d  = PH_CODE;
							end
						end
						PH_LITPIX: begin
							if (!gather_full) begin
								slot_d   = slot_inc[1:0];
								gather_d = gathered;
							end else begin
								emit     = 1'b1;
								emit_pix = gathered & mask;
								slot_d   = '0;
								gather_d = '0;
								if (!span_done) begin
									lits_d = lits_dec;
									if (lits_dec == '0) begin
										phase_d = PH_CODE;
									end
								end
							end
						end
						default: begin
							res_valid = 1'b1;
							res_kind  = KIND_EXTRA;
						end
					endcase
				end
				default: ;
			endcase

			if (emit) begin
				res_valid = 1'b1;
				res_kind  = KIND_SPAN;
				res_x     = column_q;
				res_len   = span_len;
				res_pix   = emit_pix;
				column_d  = column_q + span_len;
				if (span_done) begin
					res_le   = 1'b1;
					res_rep  = rep;
					res_pe   = pend;
					line_d   = next_line;
					column_d = '0;
					lits_d   = '0;
					run_d    = '0;
					slot_d   = '0;
					gather_d = '0;
					phase_d  = pend ? PH_IDLE : PH_REPEAT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			column_q    <= '0;
			line_q      <= '0;
			copies_q    <= '0;
			lits_q      <= '0;
			run_q       <= '0;
			slot_q      <= '0;
			gather_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			column_q <= column_d;
			line_q   <= line_d;
			copies_q <= copies_d;
			lits_q   <= lits_d;
			run_q    <= run_d;
			slot_q   <= slot_d;
			gather_q <= gather_d;
			if (pop && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			kind_q       <= res_kind;
			line_index_q <= line_q;
			start_x_q    <= res_x;
			run_length_q <= res_len;
			pixel_q      <= res_pix;
			line_end_q   <= res_le;
			repeat_q     <= res_rep;
			page_end_q   <= res_pe;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.kind         = kind_q;
	assign out_ch.line_index   = line_index_q;
	assign out_ch.start_x      = start_x_q;
	assign out_ch.run_length   = run_length_q;
	assign out_ch.pixel        = pixel_q;
	assign out_ch.line_end     = line_end_q;
	assign out_ch.repeat_count = repeat_q;
	assign out_ch.page_end     = page_end_q;

endmodule

FILE: design/raster_line_rle_decoder.sv
// top level of the raster line run-length decoder: configuration registers,
// front end, queue and decode back end; depends on rld_pkg, rld_in_if,
// rld_out_if, rld_front, rld_queue and rld_back

// decodes a packbits-style raster stream, one compressed byte per
// transaction, into pixel spans; each line opens with a repeat byte, codes
// 0 to 127 repeat the following pixel, codes -127 to -1 copy literal pixels
// and -128 fills the rest of the line with all-ones; runs are clipped at the
// line end and the line repeat is clipped at the page height. the block takes
// one transaction per clock cycle sustained while the queue is not full and
// gives at most one result per transaction; an accepted transaction is
// written into the queue, then the decode back end pops it and writes its
// result into its output register, retiring one queued transaction per
// cycle while that register is free or being taken. the queue lets input
// and output stall independently. configuration is written through a plain
// write port; the user must write it only while no transaction is in flight,
// and the block itself does not enforce this.

module raster_line_rle_decoder #(
	parameter int unsigned QUEUE_DEPTH = rld_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rld_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rld_pkg::CFG_DATA_W-1:0] cfg_wdata,
	rld_in_if.sink                         byte_ch,
	rld_out_if.source                      span_ch
);
	import rld_pkg::*;

	// configuration registers
	cfg_t    cfg_q;

	// front to queue
	logic    push;
	q_item_t push_item;
	logic    queue_full;

	// queue to back end
	logic    pop;
	q_item_t pop_item;
	logic    queue_empty;

	// register writes, an index beyond the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_width       <= COORD_W'(1);
			cfg_q.page_lines      <= COORD_W'(1);
			cfg_q.bytes_per_pixel <= BPP_W'(3);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_WIDTH:  cfg_q.row_width       <= cfg_wdata;
				REG_PAGE_LINES: cfg_q.page_lines      <= cfg_wdata;
				REG_BPP:        cfg_q.bytes_per_pixel <= cfg_wdata[BPP_W-1:0];
				default: ;
			endcase
		end
	end

	// classify each input transaction
	rld_front u_front (
		.in_ch      (byte_ch),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	// decouples acceptance from decoding
	rld_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (queue_empty)
	);

	// decode state machine and output register
	rld_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.empty    (queue_empty),
		.pop_item (pop_item),
		.pop      (pop),
		.out_ch   (span_ch)
	);

endmodule
